// ===== design/ft12_pkg.sv =====
// Shared types and codes for the FT1.2 frame receiver.
package ft12_pkg;

   // Result kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_GOOD    = 2'd2;
   localparam logic [1:0] KIND_BAD     = 2'd3;

   // Frame error codes, first one found wins
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_LENGTH = 3'd1;
   localparam logic [2:0] ERR_START  = 3'd2;
   localparam logic [2:0] ERR_CTRL   = 3'd3;
   localparam logic [2:0] ERR_CKSUM  = 3'd4;
   localparam logic [2:0] ERR_STOP   = 3'd5;

   // Control register indexes
   localparam logic [2:0] CSR_START_CHAR   = 3'd0;
   localparam logic [2:0] CSR_STOP_CHAR    = 3'd1;
   localparam logic [2:0] CSR_ACK_CHAR     = 3'd2;
   localparam logic [2:0] CSR_CONTROL_ODD  = 3'd3;
   localparam logic [2:0] CSR_CONTROL_EVEN = 3'd4;

   // Register reset values
   localparam logic [7:0] START_CHAR_RESET   = 8'd104;
   localparam logic [7:0] STOP_CHAR_RESET    = 8'd22;
   localparam logic [7:0] ACK_CHAR_RESET     = 8'd229;
   localparam logic [7:0] CONTROL_ODD_RESET  = 8'd243;
   localparam logic [7:0] CONTROL_EVEN_RESET = 8'd211;

   typedef struct packed {
      logic [7:0] start_char;
      logic [7:0] stop_char;
      logic [7:0] ack_char;
      logic [7:0] control_odd;
      logic [7:0] control_even;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [2:0] error_code;
      logic [7:0] payload_length;
   } result_type;

endpackage

// ===== design/ft12_parser.sv =====
// Frame parser: per-byte state update and result generation.
module ft12_parser
   import ft12_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEN2   = 3'd1,
      PH_START2 = 3'd2,
      PH_BODY   = 3'd3,
      PH_CKSUM  = 3'd4,
      PH_STOP   = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       start_seen_ff, start_seen_in;
   logic [7:0] length_first_ff, length_first_in;
   logic [8:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic       expect_odd_ff, expect_odd_in;
   logic [2:0] first_error_ff, first_error_in;

   logic [8:0] body_len;
   logic [8:0] bytes_next;
   logic [7:0] want_ctrl;
   logic [7:0] sum_next;
   logic [2:0] err_stop;

   // Zero length parses as one body byte
   assign body_len   = (length_first_ff == 8'd0) ? 9'd1 : {1'b0, length_first_ff};
   assign bytes_next = bytes_seen_ff + 9'd1;
   assign want_ctrl  = expect_odd_ff ? cfg.control_odd : cfg.control_even;
   assign sum_next   = running_sum_ff + rx_byte;
   assign err_stop   = ((first_error_ff == ERR_NONE) && (rx_byte != cfg.stop_char)) ?
                       ERR_STOP : first_error_ff;

   // Advance the frame state for one byte
   always_comb begin
      phase_in        = phase_ff;
      start_seen_in   = start_seen_ff;
      length_first_in = length_first_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_sum_in  = running_sum_ff;
      expect_odd_in   = expect_odd_ff;
      first_error_in  = first_error_ff;
      emit            = 1'b0;
      result          = '0;
      if (step) begin
         case (phase_ff)
            PH_LEN2: begin
               if ((rx_byte != length_first_ff) && (first_error_ff == ERR_NONE))
                  first_error_in = ERR_LENGTH;
               phase_in = PH_START2;
            end
            PH_START2: begin
               if ((rx_byte != cfg.start_char) && (first_error_ff == ERR_NONE))
                  first_error_in = ERR_START;
               phase_in      = PH_BODY;
               bytes_seen_in = 9'd0;
            end
            PH_BODY: begin
               running_sum_in = sum_next;
               bytes_seen_in  = bytes_next;
               if (bytes_next >= body_len)
                  phase_in = PH_CKSUM;
               if (bytes_seen_ff == 9'd0) begin
                  // control byte
                  if ((rx_byte != want_ctrl) && (first_error_ff == ERR_NONE))
                     first_error_in = ERR_CTRL;
               end else begin
                  emit                = 1'b1;
                  result.kind         = KIND_PAYLOAD;
                  result.payload_byte = rx_byte;
               end
            end
            PH_CKSUM: begin
               if ((rx_byte != running_sum_ff) && (first_error_ff == ERR_NONE))
                  first_error_in = ERR_CKSUM;
               phase_in = PH_STOP;
            end
            PH_STOP: begin
               emit                  = 1'b1;
               result.payload_length = 8'(body_len - 9'd1);
               if (err_stop == ERR_NONE) begin
                  result.kind = KIND_GOOD;
               end else begin
                  result.kind       = KIND_BAD;
                  result.error_code = err_stop;
               end
               expect_odd_in   = ~expect_odd_ff;
               phase_in        = PH_IDLE;
               start_seen_in   = 1'b0;
               length_first_in = 8'd0;
               bytes_seen_in   = 9'd0;
               running_sum_in  = 8'd0;
               first_error_in  = ERR_NONE;
            end
            default: begin
               // Idle, and any unused phase code
               phase_in = PH_IDLE;
               if (start_seen_ff) begin
                  start_seen_in   = 1'b0;
                  length_first_in = rx_byte;
                  bytes_seen_in   = 9'd0;
                  running_sum_in  = 8'd0;
                  first_error_in  = (rx_byte == 8'd0) ? ERR_LENGTH : ERR_NONE;
                  phase_in        = PH_LEN2;
               end else if (rx_byte == cfg.start_char) begin
                  start_seen_in = 1'b1;
               end else if (rx_byte == cfg.ack_char) begin
                  emit        = 1'b1;
                  result.kind = KIND_ACK;
               end
            end
         endcase
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         start_seen_ff   <= 1'b0;
         length_first_ff <= 8'd0;
         bytes_seen_ff   <= 9'd0;
         running_sum_ff  <= 8'd0;
         expect_odd_ff   <= 1'b1;
         first_error_ff  <= ERR_NONE;
      end else begin
         phase_ff        <= phase_in;
         start_seen_ff   <= start_seen_in;
         length_first_ff <= length_first_in;
         bytes_seen_ff   <= bytes_seen_in;
         running_sum_ff  <= running_sum_in;
         expect_odd_ff   <= expect_odd_in;
         first_error_ff  <= first_error_in;
      end
   end

endmodule

// ===== design/ft12_rsp_buffer.sv =====
// Two-entry result buffer driving the response channel.
module ft12_rsp_buffer
   import ft12_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type head
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign head      = head_ff;

   // Shift entries toward the head on each transfer out
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0)
            head_in = push_data;
         else
            tail_in = push_data;
         count_in = count_ff + 2'd1;
      end
   end

   // Hold fill count; entries need no reset
   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= 2'd0;
      else
         count_ff <= count_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== design/ft12_frame_receiver.sv =====
// Top level of the FT1.2 variable-length frame receiver.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   req     | req_valid, req_stall, req_rx_byte  | in
//   rsp     | rsp_valid, rsp_stall, rsp_kind,    | out
//           | rsp_payload_byte, rsp_error_code,  |
//           | rsp_payload_length                 |
//   csr     | csr_write_enable, csr_index,       | in
//           | csr_write_data                     |
//
// One byte per cycle while req is not stalled. A byte is registered on transfer and
// parsed from the input register once the result buffer has room. Its result (if any)
// is written to the result buffer and offered on rsp from there.
// Parsing a byte uses compares and adds on the input register.
// Reset is synchronous and restores the register defaults and idle parse state.
// req stalls only when a byte waits in the input register and both result
// buffer entries are occupied.
module ft12_frame_receiver
   import ft12_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [2:0] rsp_error_code,
   output logic [7:0] rsp_payload_length,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       req_take;
   logic       step;
   logic       buf_full;
   logic       emit;
   result_type result;
   result_type head;

   // Update control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_START_CHAR:   cfg_in.start_char   = csr_write_data;
            CSR_STOP_CHAR:    cfg_in.stop_char    = csr_write_data;
            CSR_ACK_CHAR:     cfg_in.ack_char     = csr_write_data;
            CSR_CONTROL_ODD:  cfg_in.control_odd  = csr_write_data;
            CSR_CONTROL_EVEN: cfg_in.control_even = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: advance when the buffer has room
   assign step      = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char   <= START_CHAR_RESET;
         cfg_ff.stop_char    <= STOP_CHAR_RESET;
         cfg_ff.ack_char     <= ACK_CHAR_RESET;
         cfg_ff.control_odd  <= CONTROL_ODD_RESET;
         cfg_ff.control_even <= CONTROL_EVEN_RESET;
         in_valid_ff         <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   ft12_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   ft12_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind           = head.kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_error_code     = head.error_code;
   assign rsp_payload_length = head.payload_length;

`ifndef SYNTHESIS
   // A stall on req only comes with a byte held in the input register
   a_stall_needs_held_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req stalled with empty input register");

   // Parser never pushes into a full buffer
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      emit |-> !buf_full)
      else $error("result pushed into full buffer");

   // Only a bad frame carries an error code
   a_error_only_on_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_BAD)) |-> (rsp_error_code == ERR_NONE))
      else $error("error code on a non-bad result");

   // A bad frame always names its error
   a_bad_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BAD)) |-> (rsp_error_code != ERR_NONE))
      else $error("bad frame without error code");
`endif

endmodule
